// ----- hw/rtl/smwm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sloped mute window mask - shared package
// Register indices, field widths and the beat passed to the band stage.
// ----------------------------------------------------------------------------
package smwm_pkg;

  localparam int unsigned TIDX_W     = 12;
  localparam int unsigned OFS_W      = 16;
  localparam int unsigned RATE_W     = 24;
  localparam int unsigned THR_W      = 31;
  localparam int unsigned AMP_W      = 32;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  // trace index minus a band bound
  localparam int unsigned DIFF_W     = 18;
  // elapsed samples (13 bit signed) times the rate (24 bit signed)
  localparam int unsigned PROD_W     = 37;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_START    = 3'd0,
    CFG_TIME_END      = 3'd1,
    CFG_OFFSET_LOW    = 3'd2,
    CFG_OFFSET_HIGH   = 3'd3,
    CFG_SHIFT_RATE    = 3'd4,
    CFG_AMP_THRESHOLD = 3'd5,
    CFG_USE_THRESHOLD = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                     geo_ok;
    logic [TIDX_W-1:0]        elapsed;
    logic signed [DIFF_W-1:0] dlo;
    logic signed [DIFF_W-1:0] dhi;
  } slope_req_t;

endpackage

// ----- hw/rtl/sloped_mute_window_mask_unit.sv -----
// ----------------------------------------------------------------------------
// Sloped mute window mask unit
// Returns one keep/mute bit per seismic sample from a sloped offset band,
// a time window and an optional amplitude threshold.
// ----------------------------------------------------------------------------
// One sample is taken on every clock (busy never rises) and its mask bit
// appears on mask_bit_o with the done_o strobe once the start beat has passed
// the four register stages: input, window and threshold
// tests, band-rate multiply, band compare. Results come back in order, one
// cycle each, and must be taken when shown. The user must write registers
// only while no samples are in flight; the block itself does not enforce this.
module sloped_mute_window_mask_unit #(
  parameter int unsigned MAX_TRACES     = 4096,
  parameter int unsigned MAX_SAMPLES    = 4096,
  parameter int unsigned RATE_FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [smwm_pkg::TIDX_W-1:0]            trace_index_i,
  input  logic [smwm_pkg::TIDX_W-1:0]            time_index_i,
  input  logic signed [smwm_pkg::AMP_W-1:0]      sample_value_i,
  input  logic                                   cfg_we_i,
  input  logic [smwm_pkg::CFG_IDX_W-1:0]         cfg_addr_i,
  input  logic [smwm_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  output logic                                   done_o,
  output logic                                   mask_bit_o
);
  import smwm_pkg::*;

  logic [TIDX_W-1:0]        time_start_q, time_end_q;
  logic signed [OFS_W-1:0]  offset_low_q, offset_high_q;
  logic signed [RATE_W-1:0] shift_rate_q;
  logic [THR_W-1:0]         amp_thr_q;
  logic                     use_thr_q;

  logic                     s1_vld_q;
  logic [TIDX_W-1:0]        s1_trace_q, s1_time_q;
  logic signed [AMP_W-1:0]  s1_amp_q;

  logic                     in_grid, in_win, amp_ok;
  logic [AMP_W-1:0]         amp_mag;
  slope_req_t               req_d, req_q;
  logic                     req_vld_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_start_q  <= '0;
      time_end_q    <= '0;
      offset_low_q  <= '0;
      offset_high_q <= '0;
      shift_rate_q  <= '0;
      amp_thr_q     <= '0;
      use_thr_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_TIME_START:    time_start_q  <= cfg_wdata_i[TIDX_W-1:0];
        CFG_TIME_END:      time_end_q    <= cfg_wdata_i[TIDX_W-1:0];
        CFG_OFFSET_LOW:    offset_low_q  <= $signed(cfg_wdata_i[OFS_W-1:0]);
        CFG_OFFSET_HIGH:   offset_high_q <= $signed(cfg_wdata_i[OFS_W-1:0]);
        CFG_SHIFT_RATE:    shift_rate_q  <= $signed(cfg_wdata_i[RATE_W-1:0]);
        CFG_AMP_THRESHOLD: amp_thr_q     <= cfg_wdata_i[THR_W-1:0];
        CFG_USE_THRESHOLD: use_thr_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      req_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= start && !busy;
      req_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      s1_trace_q <= trace_index_i;
      s1_time_q  <= time_index_i;
      s1_amp_q   <= sample_value_i;
    end
  end

  // window, grid and threshold tests
  assign in_grid = (32'(s1_trace_q) < 32'(MAX_TRACES)) &&
                   (32'(s1_time_q) < 32'(MAX_SAMPLES));
  assign in_win  = (s1_time_q > time_start_q) && (s1_time_q < time_end_q);
  assign amp_mag = s1_amp_q[AMP_W-1] ? (~s1_amp_q + AMP_W'(1)) : s1_amp_q;
  assign amp_ok  = !use_thr_q || (amp_mag > {1'b0, amp_thr_q});

  always_comb begin
    req_d.geo_ok  = in_grid && in_win && amp_ok;
    req_d.elapsed = s1_time_q - time_start_q;
    req_d.dlo     = $signed(DIFF_W'(s1_trace_q)) - DIFF_W'(offset_low_q);
    req_d.dhi     = $signed(DIFF_W'(s1_trace_q)) - DIFF_W'(offset_high_q);
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  smwm_band #(
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_band (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_vld_i    (req_vld_q),
    .req_i        (req_q),
    .shift_rate_i (shift_rate_q),
    .res_vld_o    (done_o),
    .res_bit_o    (mask_bit_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("sample beat without result four cycles later");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 4))
    else $error("result without a matching sample beat");

  a_mask_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_bit_o |-> done_o)
    else $error("mask bit set outside a result beat");

  a_window_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_bit_o && $past(req_vld_q, 2)) |-> $past(req_q.geo_ok, 2))
    else $error("kept sample failed window or threshold test");

endmodule

// ----- hw/rtl/smwm_band.sv -----
// ----------------------------------------------------------------------------
// Sloped mute window mask - band stage
// Multiplies elapsed samples by the band rate, truncates toward zero and
// tests the trace against the shifted band.
// ----------------------------------------------------------------------------
module smwm_band #(
  parameter int unsigned RATE_FRAC_BITS = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       req_vld_i,
  input  smwm_pkg::slope_req_t                       req_i,
  input  logic signed [smwm_pkg::RATE_W-1:0]         shift_rate_i,
  output logic                                       res_vld_o,
  output logic                                       res_bit_o
);
  import smwm_pkg::*;

  localparam logic signed [PROD_W-1:0] RndBias =
    PROD_W'((64'(1) << RATE_FRAC_BITS) - 64'(1));

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [PROD_W-1:0] shift;
  logic signed [DIFF_W-1:0] dlo_q, dhi_q;
  logic                     geo_ok_q;
  logic                     mul_vld_q;
  logic                     band_ok;
  logic                     res_vld_q, res_bit_q;

  assign prod_d = $signed({1'b0, req_i.elapsed}) * shift_rate_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= req_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    dlo_q    <= req_i.dlo;
    dhi_q    <= req_i.dhi;
    geo_ok_q <= req_i.geo_ok;
  end

  // truncate toward zero
  assign shift   = (prod_q + (prod_q[PROD_W-1] ? RndBias : PROD_W'(0))) >>> RATE_FRAC_BITS;
  assign band_ok = (PROD_W'(dlo_q) > shift) && (PROD_W'(dhi_q) < shift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
      res_bit_q <= 1'b0;
    end else begin
      res_vld_q <= mul_vld_q;
      res_bit_q <= mul_vld_q && geo_ok_q && band_ok;
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_bit_o = res_bit_q;

endmodule
